// ===== rtl/twe_pkg.sv =====
`default_nettype none
package twe_pkg;

    // table size and time width
    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 24;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TSUM_W    = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_RESET = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_STARTED = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_VALUE   = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_ACK     = 3'd4;

    // easing curves
    localparam logic [1:0] CURVE_LINEAR   = 2'd0;
    localparam logic [1:0] CURVE_EXPO_IN  = 2'd1;
    localparam logic [1:0] CURVE_EXPO_OUT = 2'd2;

    typedef logic [TIME_BITS-1:0] t_time;

    // one slot entry in the table memory
    typedef struct packed {
        logic [31:0] from_value;
        logic [31:0] to_value;
        t_time       length_time;
        t_time       wait_time;
        t_time       elapsed;
        logic [1:0]  curve;
        logic [1:0]  flags;     // bit 0 target, bit 1 tick
    } t_slot;

    // memory port control
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_mem_ctl;

    // one result beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] value;
        logic        value_valid;
        logic        tick_event;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DIV,
        ST_EASE1,
        ST_EASE2,
        ST_MUL,
        ST_SUM,
        ST_EMIT,
        ST_FLUSH
    } t_state;

    // 2^(i/16) in Q2.16
    function automatic logic [17:0] pow2_entry(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/twe_slot_mem.sv =====
`default_nettype none
module twe_slot_mem
    import twe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_ctl i_ctl,
    input  wire t_slot    i_wdata,
    output t_slot         o_rdata
);

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/twe_div.sv =====
`default_nettype none
module twe_div
    import twe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_time       i_num,
    input  wire t_time       i_den,
    output logic             o_done,
    output logic [15:0]      o_quot
);

    logic               r_busy;
    logic               r_done;
    logic [3:0]         r_cnt;
    t_time              r_rem;
    t_time              r_den;
    logic [15:0]        r_quot;
    t_time              n_rem;
    logic [TIME_BITS:0] rem2;
    logic               ge;

    // restoring step, one quotient bit per cycle (num < den)
    always_comb begin
        rem2  = {r_rem, 1'b0};
        ge    = rem2 >= {1'b0, r_den};
        n_rem = ge ? TIME_BITS'(rem2 - {1'b0, r_den}) : TIME_BITS'(rem2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[14:0], ge};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== rtl/tween_interpolation_engine.sv =====
`default_nettype none
// channel  | dir | beat contents
// s_axis   | in  | tuser: action[1:0]; tdata: slot, delta_time, start_value, end_value,
//          |     |   duration, delay, ease, has_target, wants_tick
// m_axis   | out | tuser: kind[2:0]; tdata: slot_out, value, value_valid, tick_event;
//          |     |   tlast: last result of the input beat
// Start, stop and reset pass through the flush state, which waits out any output stall.
// A tick walks slots from the top down: a free slot is only scanned, a waiting or
// silent slot is read and written back; an emitting slot also runs the 16-step divider.
// Slot state sits in a table memory with one write and one read port; reset clears only
// the active bits.
// Input is taken only when the previous beat's results are all handed to the output.
module tween_interpolation_engine
    import twe_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [135:0] i_s_tdata,   // slot, delta_time, start_value, end_value,
                                           // duration, delay, ease, has_target, wants_tick
    input  wire logic [1:0]   i_s_tuser,   // action
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [39:0]       o_m_tdata,   // slot_out, value, value_valid, tick_event, pad
    output logic [2:0]        o_m_tuser,   // kind
    output logic              o_m_tlast
);

    // input fields
    logic [3:0]  in_slot;
    logic [15:0] in_dt;
    logic [31:0] in_start;
    logic [31:0] in_end;
    logic [23:0] in_dur;
    logic [23:0] in_delay;
    logic [1:0]  in_ease;
    logic        in_target;
    logic        in_tick;

    assign in_slot   = i_s_tdata[3:0];
    assign in_dt     = i_s_tdata[19:4];
    assign in_start  = i_s_tdata[51:20];
    assign in_end    = i_s_tdata[83:52];
    assign in_dur    = i_s_tdata[107:84];
    assign in_delay  = i_s_tdata[131:108];
    assign in_ease   = i_s_tdata[133:132];
    assign in_target = i_s_tdata[134];
    assign in_tick   = i_s_tdata[135];

    t_state            r_state, n_state;
    logic [SLOTS-1:0]  r_active;
    logic [SLOT_W-1:0] r_idx;
    logic [15:0]       r_dt;
    logic [31:0]       r_from, r_to;
    logic [1:0]        r_curve, r_flags;
    logic [17:0]       r_lo, r_dif;
    logic [11:0]       r_frac;
    logic [3:0]        r_n;
    logic              r_fz, r_kz;
    logic [15:0]       r_k;
    logic [16:0]       r_ease;
    logic signed [50:0] r_prod;
    t_res              r_new, r_pend, r_out;
    logic              r_pend_v, r_out_v, r_out_last;

    t_mem_ctl          mem_ctl;
    t_slot             mem_wdata, rd, wb;
    logic              div_start, div_done;
    logic [15:0]       div_quot;

    logic              accept, out_free;
    logic              out_push, push_last, take_new, step_next;

    // table memory and divider
    twe_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_wdata (mem_wdata),
        .o_rdata (rd)
    );

    twe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (wb.elapsed),
        .i_den   (rd.length_time),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_v || i_m_tready;

    // lowest free slot
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // slot update: delay countdown or elapsed advance
    logic [TSUM_W-1:0] t_sum;
    t_time             el_new, wait_new;
    logic              waiting, finished;
    always_comb begin
        t_sum    = TSUM_W'(rd.elapsed) + TSUM_W'(r_dt);
        el_new   = (t_sum > TSUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(t_sum);
        wait_new = (TSUM_W'(rd.wait_time) > TSUM_W'(r_dt)) ?
                   TIME_BITS'(TSUM_W'(rd.wait_time) - TSUM_W'(r_dt)) : '0;
        waiting  = rd.wait_time != '0;
        finished = el_new >= rd.length_time;
        wb       = rd;
        if (waiting) begin
            wb.wait_time = wait_new;
        end else begin
            wb.elapsed = el_new;
        end
    end

    // ease stage 1: exponent split and table lookup
    logic [19:0] e10;
    logic [15:0] pw_arg;
    logic [17:0] tab_lo, tab_hi;
    always_comb begin
        e10    = 20'(div_quot) * 20'd10;
        pw_arg = (r_curve == CURVE_EXPO_OUT) ? 16'(17'h10000 - {1'b0, e10[15:0]})
                                             : e10[15:0];
        tab_lo = pow2_entry({1'b0, pw_arg[15:12]});
        tab_hi = pow2_entry({1'b0, pw_arg[15:12]} + 5'd1);
    end

    // ease stage 2: interpolate 2^f, rounded shift, curve select
    logic [29:0] lerp;
    logic [18:0] pw;
    logic [3:0]  sh;
    logic [19:0] rs;
    logic [16:0] ease_val;
    always_comb begin
        lerp = 30'(r_dif) * 30'(r_frac) + 30'd2048;
        pw   = 19'(r_lo) + 19'(lerp >> 12);
        sh   = (r_curve == CURVE_EXPO_OUT) ? r_n + 4'd1 : 4'd10 - r_n;
        rs   = (20'(pw) + (20'd1 << (sh - 4'd1))) >> sh;
        case (r_curve)
            CURVE_LINEAR:   ease_val = 17'(r_k);
            CURVE_EXPO_IN:  ease_val = r_kz ? 17'd0 : 17'(rs);
            CURVE_EXPO_OUT: ease_val = r_fz ? 17'h10000 - (17'h10000 >> r_n)
                                            : 17'h10000 - 17'(rs);
            default:        ease_val = 17'd0;
        endcase
    end

    // interpolation product and final sum
    logic signed [32:0] diff;
    logic signed [50:0] mul;
    logic signed [50:0] q;
    always_comb begin
        diff = $signed({r_to[31], r_to}) - $signed({r_from[31], r_from});
        mul  = diff * $signed({1'b0, r_ease}) + 51'sd32768;
        q    = r_prod >>> 16;
    end

    // control outputs
    always_comb begin
        mem_ctl   = '0;
        mem_wdata = wb;
        div_start = 1'b0;
        out_push  = 1'b0;
        push_last = 1'b0;
        take_new  = 1'b0;
        step_next = 1'b0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (accept && i_s_tuser == ACT_START && free_found) begin
                    mem_ctl.we            = 1'b1;
                    mem_ctl.waddr         = free_idx;
                    mem_wdata.from_value  = in_start;
                    mem_wdata.to_value    = in_end;
                    mem_wdata.length_time = TIME_BITS'(in_dur);
                    mem_wdata.wait_time   = TIME_BITS'(in_delay);
                    mem_wdata.elapsed     = '0;
                    mem_wdata.curve       = in_ease;
                    mem_wdata.flags       = {in_tick, in_target};
                end
            end
            ST_SCAN: begin
                if (r_active[r_idx]) begin
                    mem_ctl.re    = 1'b1;
                    mem_ctl.raddr = r_idx;
                end else begin
                    step_next = 1'b1;
                end
            end
            ST_EVAL: begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = r_idx;
                if (waiting || (!finished && rd.flags == 2'd0)) begin
                    step_next = 1'b1;
                end else if (!finished) begin
                    div_start = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_pend_v) begin
                    take_new  = 1'b1;
                    step_next = 1'b1;
                end else if (out_free) begin
                    out_push  = 1'b1;
                    take_new  = 1'b1;
                    step_next = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (r_pend_v && out_free) begin
                    out_push  = 1'b1;
                    push_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_s_tuser == ACT_TICK) ? ST_SCAN : ST_FLUSH;
                end
            end
            ST_SCAN: begin
                if (r_active[r_idx]) begin
                    n_state = ST_EVAL;
                end else begin
                    n_state = (r_idx == '0) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_EVAL: begin
                if (step_next) begin
                    n_state = (r_idx == '0) ? ST_FLUSH : ST_SCAN;
                end else if (finished) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:   n_state = div_done ? ST_EASE1 : ST_DIV;
            ST_EASE1: n_state = ST_EASE2;
            ST_EASE2: n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (step_next) begin
                    n_state = (r_idx == '0) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state, active bits, result staging
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;

            // output register
            if (out_push) begin
                r_out_v    <= 1'b1;
                r_out      <= r_pend;
                r_out_last <= push_last;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end

            // pending result: held until the next one shows whether it is last
            if (take_new) begin
                r_pend   <= r_new;
                r_pend_v <= 1'b1;
            end else if (out_push) begin
                r_pend_v <= 1'b0;
            end

            if (step_next && r_idx != '0) begin
                r_idx <= r_idx - SLOT_W'(1);
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_pend_v <= i_s_tuser != ACT_TICK;
                        case (i_s_tuser)
                            ACT_START: begin
                                if (free_found) begin
                                    r_active[free_idx] <= 1'b1;
                                    r_pend <= {KIND_STARTED, 4'(free_idx), 32'd0, 2'b00};
                                end else begin
                                    r_pend <= {KIND_FULL, 4'd0, 32'd0, 2'b00};
                                end
                            end
                            ACT_STOP: begin
                                if ({28'd0, in_slot} < 32'(SLOTS)) begin
                                    r_active[SLOT_W'(in_slot)] <= 1'b0;
                                end
                                r_pend <= {KIND_ACK, in_slot, 32'd0, 2'b00};
                            end
                            ACT_RESET: begin
                                r_active <= '0;
                                r_pend   <= {KIND_ACK, 4'd0, 32'd0, 2'b00};
                            end
                            default: begin
                                r_idx <= SLOT_W'(SLOTS - 1);
                                r_dt  <= in_dt;
                            end
                        endcase
                    end
                end
                ST_EVAL: begin
                    r_from  <= rd.from_value;
                    r_to    <= rd.to_value;
                    r_curve <= rd.curve;
                    r_flags <= rd.flags;
                    if (!waiting && finished) begin
                        r_active[r_idx] <= 1'b0;
                        r_new           <= {KIND_DONE, 4'(r_idx), 32'd0, 2'b00};
                    end
                end
                ST_EASE1: begin
                    r_lo   <= tab_lo;
                    r_dif  <= tab_hi - tab_lo;
                    r_frac <= pw_arg[11:0];
                    r_n    <= e10[19:16];
                    r_fz   <= e10[15:0] == 16'd0;
                    r_kz   <= div_quot == 16'd0;
                    r_k    <= div_quot;
                end
                ST_EASE2: r_ease <= ease_val;
                ST_MUL:   r_prod <= mul;
                ST_SUM: begin
                    // kind, slot, value, value_valid, tick_event
                    r_new <= {KIND_VALUE, 4'(r_idx),
                              r_flags[0] ? r_from + q[31:0] : 32'd0,
                              r_flags[0], r_flags[1]};
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {2'b00, r_out.tick_event, r_out.value_valid, r_out.value, r_out.slot};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

// ===== tb/tb_tween_interpolation_engine.sv =====
`timescale 1ns / 1ps

module tb_tween_interpolation_engine;
    import twe_pkg::*;

    // one result beat as seen on the master side
    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] value;
        logic        vv;
        logic        te;
        logic        last;
    } t_beat;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [135:0] i_s_tdata;   // slot, delta_time, start_value, end_value,
                               // duration, delay, ease, has_target, wants_tick
    logic [1:0]   i_s_tuser;   // action
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [39:0]  o_m_tdata;   // slot_out, value, value_valid, tick_event, pad
    logic [2:0]   o_m_tuser;   // kind
    logic         o_m_tlast;

    tween_interpolation_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    localparam int CYCLE_LIMIT = 2000000;

    // predicted slot table
    logic        slot_busy  [SLOTS];
    logic [31:0] slot_from  [SLOTS];
    logic [31:0] slot_to    [SLOTS];
    t_time       slot_len   [SLOTS];
    t_time       slot_wait  [SLOTS];
    t_time       slot_elap  [SLOTS];
    logic [1:0]  slot_curve [SLOTS];
    logic [1:0]  slot_flags [SLOTS];

    t_beat pending_results[$];
    int   mismatches;
    int   cycles;
    bit   no_gaps;   // stretch with no idling on either side
    int   ready_wait;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        if (no_gaps) return 0;
        return $urandom_range(0, 10);
    endfunction

    // 2^f for f in Q0.16, result Q16.16, interpolated table
    function automatic logic [31:0] exp2_frac(input logic [31:0] f);
        logic [31:0] lut [17];
        logic [31:0] lo;
        logic [31:0] hi;
        lut = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
                96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
        lo = lut[{1'b0, f[15:12]}];
        hi = lut[{1'b0, f[15:12]} + 5'd1];
        return lo + (((hi - lo) * f[11:0] + 32'd2048) >> 12);
    endfunction

    function automatic logic [31:0] rshift_round(input logic [31:0] v, input int s);
        return (v + (32'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic [31:0] ease_of(input logic [1:0] c, input logic [31:0] k);
        logic [31:0] e;
        int          n;
        logic [31:0] f;
        logic [31:0] p;
        e = 32'd10 * k;
        n = e >> 16;
        f = e & 32'hFFFF;
        case (c)
            CURVE_LINEAR: return k;
            CURVE_EXPO_IN: begin
                if (k == 0) return 0;
                return rshift_round(exp2_frac(f), 10 - n);
            end
            CURVE_EXPO_OUT: begin
                if (f == 0) p = 32'd65536 >> n;
                else p = rshift_round(exp2_frac(32'd65536 - f), n + 1);
                return 32'd65536 - p;
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic [31:0] lerp_q16(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] w);
        logic signed [63:0] sa;
        logic signed [63:0] d;
        logic signed [63:0] p;
        sa = 64'(signed'(a));
        d  = 64'(signed'(b)) - sa;
        p  = d * $signed({32'd0, w}) + 64'sd32768;
        return 32'(sa + (p >>> 16));
    endfunction

    function automatic void push_result(input logic [2:0] kind, input int sl,
                                        input logic [31:0] v, input logic vv,
                                        input logic te);
        t_beat r;
        r.kind = kind; r.slot = 4'(sl); r.value = v; r.vv = vv; r.te = te; r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // advance the slot table by one accepted beat, queue the results it causes
    function automatic void predict_beat(input logic [1:0] act, input logic [135:0] d);
        int          n;
        int          sl;
        logic [15:0] dt;
        logic [63:0] t;
        logic [31:0] k;
        logic [31:0] v;
        n  = pending_results.size();
        dt = d[19:4];
        case (act)
            ACT_START: begin
                sl = -1;
                for (int i = SLOTS - 1; i >= 0; i--) if (!slot_busy[i]) sl = i;
                if (sl < 0) begin
                    push_result(KIND_FULL, 0, 0, 0, 0);
                end else begin
                    slot_busy[sl]  = 1'b1;
                    slot_from[sl]  = d[51:20];
                    slot_to[sl]    = d[83:52];
                    slot_len[sl]   = d[107:84];
                    slot_wait[sl]  = d[131:108];
                    slot_elap[sl]  = 0;
                    slot_curve[sl] = d[133:132];
                    slot_flags[sl] = d[135:134];
                    push_result(KIND_STARTED, sl, 0, 0, 0);
                end
            end
            ACT_STOP: begin
                if (d[3:0] < SLOTS) slot_busy[d[3:0]] = 1'b0;
                push_result(KIND_ACK, d[3:0], 0, 0, 0);
            end
            ACT_RESET: begin
                for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
                push_result(KIND_ACK, 0, 0, 0, 0);
            end
            default: begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_busy[i]) continue;
                    if (slot_wait[i] > 0) begin
                        slot_wait[i] = (slot_wait[i] > dt) ? slot_wait[i] - dt : 0;
                        continue;
                    end
                    t = 64'(slot_elap[i]) + dt;
                    slot_elap[i] = (t > TIME_MAX) ? TIME_MAX : t[TIME_BITS-1:0];
                    if (slot_elap[i] >= slot_len[i]) begin
                        slot_busy[i] = 1'b0;
                        push_result(KIND_DONE, i, 0, 0, 0);
                        continue;
                    end
                    if (slot_flags[i] != 0) begin
                        k = 32'((64'(slot_elap[i]) << 16) / slot_len[i]) & 32'hFFFF;
                        v = slot_flags[i][0] ?
                            lerp_q16(slot_from[i], slot_to[i], ease_of(slot_curve[i], k)) : 0;
                        push_result(KIND_VALUE, i, v, slot_flags[i][0], slot_flags[i][1]);
                    end
                end
            end
        endcase
        if (pending_results.size() > n)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // drive one beat, wait for it to be taken, then idle for a drawn gap
    task automatic send_beat(input logic [1:0] act, input logic [3:0] sl,
                             input logic [15:0] dt, input logic [31:0] from_v,
                             input logic [31:0] to_v, input logic [23:0] dur,
                             input logic [23:0] dly, input logic [1:0] crv,
                             input logic tgt, input logic tck);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {tck, tgt, crv, dly, dur, to_v, from_v, dt, sl};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_beat(i_s_tuser, i_s_tdata);
        gap = draw_wait();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_tick(input logic [15:0] dt);
        send_beat(ACT_TICK, 4'($urandom), dt, $urandom, $urandom, 24'($urandom),
                  24'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // fill the table with extreme settings, then one start too many
    task automatic test_fill_table();
        send_beat(ACT_START, 0, 0, 32'h7FFFFFFF, 32'h80000000, 24'd1000, 0,
                  CURVE_LINEAR, 1, 1);
        send_beat(ACT_START, 0, 0, 32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF, 0,
                  CURVE_EXPO_IN, 1, 0);
        send_beat(ACT_START, 0, 0, 32'h00010000, 32'hFFFF0000, 24'd700, 0,
                  CURVE_EXPO_OUT, 1, 1);
        send_beat(ACT_START, 0, 0, 32'h12345678, 32'h00000000, 24'd500, 0,
                  2'd3, 1, 0);
        send_beat(ACT_START, 0, 0, 0, 0, 24'd0, 0, CURVE_LINEAR, 0, 1);
        send_beat(ACT_START, 0, 0, 0, 0, 24'd100, 24'hFFFFFF, CURVE_LINEAR, 1, 1);
        send_beat(ACT_START, 0, 0, 0, 32'h00640000, 24'd300, 24'd10, CURVE_LINEAR, 0, 0);
        for (int i = 7; i < SLOTS; i++)
            send_beat(ACT_START, 0, 0, $urandom, $urandom, 24'($urandom_range(1, 4000)),
                      $urandom_range(0, 3) == 0 ? 24'd5 : 24'd0,
                      2'($urandom_range(0, 2)), 1'($urandom), 1'($urandom));
        send_beat(ACT_START, 0, 0, 1, 2, 3, 4, CURVE_LINEAR, 1, 1);
        wait_drained();
    endtask

    // ticks at both ends of delta, then stop, reset and one more tick
    task automatic test_ticks_stop_reset();
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'd400);
        send_tick(16'hFFFF);
        send_beat(ACT_STOP, 4'd15, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(ACT_STOP, 4'd0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(ACT_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tick(16'd5);
        wait_drained();
    endtask

    // mostly starts and short ticks, so slots run through delay, motion and finish
    task automatic test_random_traffic();
        int r;
        for (int n = 0; n < 400; n++) begin
            if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_beat(ACT_START, 4'($urandom), 16'($urandom), $urandom, $urandom,
                          $urandom_range(0, 19) == 0 ? 24'($urandom)
                                                     : 24'($urandom_range(0, 300)),
                          $urandom_range(0, 29) == 0 ? 24'($urandom)
                          : ($urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(1, 100))),
                          2'($urandom), 1'($urandom), 1'($urandom));
            end else if (r < 82) begin
                send_tick($urandom_range(0, 19) == 0 ? 16'($urandom)
                                                     : 16'($urandom_range(0, 40)));
            end else if (r < 97) begin
                send_beat(ACT_STOP, 4'($urandom), 16'($urandom), $urandom, $urandom,
                          24'($urandom), 24'($urandom), 2'($urandom), 1'($urandom),
                          1'($urandom));
            end else begin
                send_beat(ACT_RESET, 4'($urandom), 16'($urandom), $urandom, $urandom,
                          24'($urandom), 24'($urandom), 2'($urandom), 1'($urandom),
                          1'($urandom));
            end
        end
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // master side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_wait = 0;
            i_m_tready <= 1'b1;
        end else if (o_m_tvalid && i_m_tready) begin
            ready_wait = draw_wait();
            i_m_tready <= (ready_wait == 0);
        end else if (ready_wait > 0) begin
            ready_wait--;
            i_m_tready <= (ready_wait == 0);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected beat kind=%0d slot=%0d value=%h",
                             o_m_tuser, o_m_tdata[3:0], o_m_tdata[35:4]);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser !== want.kind || o_m_tdata[3:0] !== want.slot ||
                    o_m_tdata[35:4] !== want.value || o_m_tdata[36] !== want.vv ||
                    o_m_tdata[37] !== want.te || o_m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp kind=%0d slot=%0d val=%h vv=%b te=%b last=%b,",
                                 want.kind, want.slot, want.value, want.vv, want.te,
                                 want.last,
                                 " got kind=%0d slot=%0d val=%h vv=%b te=%b last=%b",
                                 o_m_tuser, o_m_tdata[3:0], o_m_tdata[35:4],
                                 o_m_tdata[36], o_m_tdata[37], o_m_tlast);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        cycles     = 0;
        no_gaps    = 1'b0;
        for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_table();
        test_ticks_stop_reset();
        test_random_traffic();

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/twe_pkg.sv
rtl/twe_slot_mem.sv
rtl/twe_div.sv
rtl/tween_interpolation_engine.sv
tb/tb_tween_interpolation_engine.sv
